// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");

// Implication that must hold at every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("%m: assertion failed");

`endif

// ===== hdl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

  // Default channel width.
  localparam int unsigned CHANNEL_BITS_DEF = 8;

  // Hue arithmetic.
  localparam int unsigned HUE_BITS       = 9;
  localparam int unsigned HUE_QBITS      = 6;    // quotient of 60*diff/delta is at most 60
  localparam int unsigned HUE_SCALE      = 60;
  localparam int unsigned HUE_GREEN_BASE = 120;
  localparam int unsigned HUE_BLUE_BASE  = 240;
  localparam int unsigned HUE_FULL_TURN  = 360;

  // Pipeline stages outside the divider: prepare, multiply, output register.
  localparam int unsigned EXTRA_STAGES = 3;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rgbhsv_sector_e;

  // Control that travels alongside each pixel through the pipeline.
  typedef struct packed {
    logic           valid;
    logic           grey;   // max equals min
    logic           black;  // max is zero
    rgbhsv_sector_e sector;
    logic           neg;    // hue offset is negative
  } rgbhsv_ctrl_t;

endpackage

// ===== hdl/rgbhsv_prep.sv =====
module rgbhsv_prep #(
  parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       valid_i,
  input  logic [CHANNEL_BITS-1:0]                    red_i,
  input  logic [CHANNEL_BITS-1:0]                    green_i,
  input  logic [CHANNEL_BITS-1:0]                    blue_i,
  output rgbhsv_pkg::rgbhsv_ctrl_t                   ctrl_o,
  output logic [CHANNEL_BITS-1:0]                    max_o,
  output logic [CHANNEL_BITS-1:0]                    delta_o,
  output logic [CHANNEL_BITS+rgbhsv_pkg::HUE_QBITS-1:0] hue_num_o,
  output logic [2*CHANNEL_BITS-1:0]                  sat_num_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned W  = CHANNEL_BITS;
  localparam int unsigned HW = CHANNEL_BITS + HUE_QBITS;

  // First stage: extremes, sector and the hue difference as magnitude and sign.
  logic [W-1:0]   max_c, min_c, op_a, op_b, diff_c;
  rgbhsv_sector_e sector_c;
  rgbhsv_ctrl_t   ctrl_a_d, ctrl_a_q;
  logic [W-1:0]   max_a_q, delta_a_q, diff_a_q;

  always_comb begin
    max_c = red_i;
    if (green_i > max_c) max_c = green_i;
    if (blue_i > max_c) max_c = blue_i;
    min_c = red_i;
    if (green_i < min_c) min_c = green_i;
    if (blue_i < min_c) min_c = blue_i;

    if (max_c == red_i) begin
      sector_c = SEC_RED;
      op_a     = green_i;
      op_b     = blue_i;
    end else if (max_c == green_i) begin
      sector_c = SEC_GREEN;
      op_a     = blue_i;
      op_b     = red_i;
    end else begin
      sector_c = SEC_BLUE;
      op_a     = red_i;
      op_b     = green_i;
    end
    diff_c = (op_a < op_b) ? (op_b - op_a) : (op_a - op_b);

    ctrl_a_d.valid  = valid_i;
    ctrl_a_d.grey   = (max_c == min_c);
    ctrl_a_d.black  = (max_c == '0);
    ctrl_a_d.sector = sector_c;
    ctrl_a_d.neg    = (op_a < op_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_a_q <= '0;
    end else begin
      ctrl_a_q <= ctrl_a_d;
    end
  end

  always_ff @(posedge clk_i) begin
    max_a_q   <= max_c;
    delta_a_q <= max_c - min_c;
    diff_a_q  <= diff_c;
  end

  // Second stage: scale the numerators of both divisions.
  rgbhsv_ctrl_t         ctrl_b_q;
  logic [W-1:0]         max_b_q, delta_b_q;
  logic [HW-1:0]        hue_num_d, hue_num_q;
  logic [2*W-1:0]       sat_num_d, sat_num_q;

  assign hue_num_d = HW'(diff_a_q) * HW'(HUE_SCALE);
  // The full-scale code times delta is delta shifted up by W minus delta.
  assign sat_num_d = {delta_a_q, {W{1'b0}}} - (2*W)'(delta_a_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_b_q <= '0;
    end else begin
      ctrl_b_q <= ctrl_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    max_b_q   <= max_a_q;
    delta_b_q <= delta_a_q;
    hue_num_q <= hue_num_d;
    sat_num_q <= sat_num_d;
  end

  assign ctrl_o    = ctrl_b_q;
  assign max_o     = max_b_q;
  assign delta_o   = delta_b_q;
  assign hue_num_o = hue_num_q;
  assign sat_num_o = sat_num_q;

endmodule

// ===== hdl/rgbhsv_div.sv =====
module rgbhsv_div #(
  parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  rgbhsv_pkg::rgbhsv_ctrl_t                      ctrl_i,
  input  logic [CHANNEL_BITS-1:0]                       max_i,
  input  logic [CHANNEL_BITS-1:0]                       delta_i,
  input  logic [CHANNEL_BITS+rgbhsv_pkg::HUE_QBITS-1:0] hue_num_i,
  input  logic [2*CHANNEL_BITS-1:0]                     sat_num_i,
  output rgbhsv_pkg::rgbhsv_ctrl_t                      ctrl_o,
  output logic [CHANNEL_BITS-1:0]                       max_o,
  output logic [rgbhsv_pkg::HUE_QBITS-1:0]              hue_quo_o,
  output logic [CHANNEL_BITS-1:0]                       sat_quo_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned W  = CHANNEL_BITS;
  localparam int unsigned HQ = HUE_QBITS;
  localparam int unsigned NS = (W > HQ) ? W : HQ;

  // Restoring division, one quotient bit per stage. The saturation quotient
  // takes W stages and the hue quotient HQ stages; whichever finishes first
  // rides along until the last stage. Both quotients are known to fit, so
  // each remainder starts from the upper part of its numerator.
  rgbhsv_ctrl_t   ctrl_q [1:NS];
  logic [W-1:0]   max_q  [1:NS];
  logic [W-1:0]   squo_q [1:NS];
  logic [HQ-1:0]  hquo_q [1:NS];
  logic [W-1:0]   srem_q [1:W-1];
  logic [W-1:0]   slo_q  [1:W-1];
  logic [W-1:0]   hrem_q [1:HQ-1];
  logic [HQ-1:0]  hlo_q  [1:HQ-1];
  logic [W-1:0]   delta_q[1:HQ-1];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    rgbhsv_ctrl_t  s_ctrl;
    logic [W-1:0]  s_max, s_quo, s_quo_nx;
    logic [HQ-1:0] h_quo, h_quo_nx;

    if (k == 0) begin : g_src_first
      assign s_ctrl = ctrl_i;
      assign s_max  = max_i;
      assign s_quo  = '0;
      assign h_quo  = '0;
    end else begin : g_src_rest
      assign s_ctrl = ctrl_q[k];
      assign s_max  = max_q[k];
      assign s_quo  = squo_q[k];
      assign h_quo  = hquo_q[k];
    end

    if (k < W) begin : g_sat
      logic [W-1:0] s_rem, s_lo, s_rem_nx;
      logic [W:0]   s_trial;
      logic         s_ge;

      if (k == 0) begin : g_ssrc_first
        assign s_rem = sat_num_i[2*W-1:W];
        assign s_lo  = sat_num_i[W-1:0];
      end else begin : g_ssrc_rest
        assign s_rem = srem_q[k];
        assign s_lo  = slo_q[k];
      end

      assign s_trial  = {s_rem, s_lo[W-1]};
      assign s_ge     = (s_trial >= {1'b0, s_max});
      assign s_rem_nx = s_ge ? W'(s_trial - {1'b0, s_max}) : s_trial[W-1:0];
      assign s_quo_nx = {s_quo[W-2:0], s_ge};

      if (k < W - 1) begin : g_sreg
        always_ff @(posedge clk_i) begin
          srem_q[k+1] <= s_rem_nx;
          slo_q[k+1]  <= {s_lo[W-2:0], 1'b0};
        end
      end
    end else begin : g_sat_done
      assign s_quo_nx = s_quo;
    end

    if (k < HQ) begin : g_hue
      logic [W-1:0]  h_rem, h_delta, h_rem_nx;
      logic [HQ-1:0] h_lo;
      logic [W:0]    h_trial;
      logic          h_ge;

      if (k == 0) begin : g_hsrc_first
        assign h_rem   = hue_num_i[W+HQ-1:HQ];
        assign h_lo    = hue_num_i[HQ-1:0];
        assign h_delta = delta_i;
      end else begin : g_hsrc_rest
        assign h_rem   = hrem_q[k];
        assign h_lo    = hlo_q[k];
        assign h_delta = delta_q[k];
      end

      assign h_trial  = {h_rem, h_lo[HQ-1]};
      assign h_ge     = (h_trial >= {1'b0, h_delta});
      assign h_rem_nx = h_ge ? W'(h_trial - {1'b0, h_delta}) : h_trial[W-1:0];
      assign h_quo_nx = {h_quo[HQ-2:0], h_ge};

      if (k + 1 < HQ) begin : g_hreg
        always_ff @(posedge clk_i) begin
          hrem_q[k+1]  <= h_rem_nx;
          hlo_q[k+1]   <= {h_lo[HQ-2:0], 1'b0};
          delta_q[k+1] <= h_delta;
        end
      end
    end else begin : g_hue_done
      assign h_quo_nx = h_quo;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctrl_q[k+1] <= '0;
      end else begin
        ctrl_q[k+1] <= s_ctrl;
      end
    end

    always_ff @(posedge clk_i) begin
      max_q[k+1]  <= s_max;
      squo_q[k+1] <= s_quo_nx;
      hquo_q[k+1] <= h_quo_nx;
    end
  end

  assign ctrl_o    = ctrl_q[NS];
  assign max_o     = max_q[NS];
  assign hue_quo_o = hquo_q[NS];
  assign sat_quo_o = squo_q[NS];

endmodule

// ===== hdl/rgbhsv_final.sv =====
module rgbhsv_final #(
  parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  rgbhsv_pkg::rgbhsv_ctrl_t            ctrl_i,
  input  logic [CHANNEL_BITS-1:0]             max_i,
  input  logic [rgbhsv_pkg::HUE_QBITS-1:0]    hue_quo_i,
  input  logic [CHANNEL_BITS-1:0]             sat_quo_i,
  output logic                                done_o,
  output logic [rgbhsv_pkg::HUE_BITS-1:0]     hue_deg_o,
  output logic [CHANNEL_BITS-1:0]             saturation_o,
  output logic [CHANNEL_BITS-1:0]             brightness_o
);
  import rgbhsv_pkg::*;

  logic [HUE_BITS-1:0]     quo_ext, hue_d, hue_q;
  logic [CHANNEL_BITS-1:0] sat_d, sat_q, bright_q;
  logic                    done_q;

  assign quo_ext = HUE_BITS'(hue_quo_i);

  always_comb begin
    case (ctrl_i.sector)
      SEC_RED: begin
        // A negative offset wraps around the circle; minus zero stays zero.
        if (ctrl_i.neg && (hue_quo_i != '0)) begin
          hue_d = HUE_BITS'(HUE_FULL_TURN) - quo_ext;
        end else begin
          hue_d = quo_ext;
        end
      end
      SEC_GREEN: begin
        hue_d = ctrl_i.neg ? HUE_BITS'(HUE_GREEN_BASE) - quo_ext
                           : HUE_BITS'(HUE_GREEN_BASE) + quo_ext;
      end
      SEC_BLUE: begin
        hue_d = ctrl_i.neg ? HUE_BITS'(HUE_BLUE_BASE) - quo_ext
                           : HUE_BITS'(HUE_BLUE_BASE) + quo_ext;
      end
      default: begin
        hue_d = '0;
      end
    endcase
    if (ctrl_i.grey) hue_d = '0;
    sat_d = ctrl_i.black ? '0 : sat_quo_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= hue_d;
    sat_q    <= sat_d;
    bright_q <= max_i;
  end

  assign done_o       = done_q;
  assign hue_deg_o    = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

endmodule

// ===== hdl/rgb_to_hsv_converter_top.sv =====
// RGB to HSV pixel converter.
// A pixel transaction is accepted at each rising edge where start_i is high and
// busy_o is low. The pipeline never refuses a pixel, so busy_o stays low and a
// new pixel may be presented in every clock cycle.
// The result transaction appears on hue_deg_o, saturation_o and brightness_o
// for exactly one cycle, marked by done_o. Results leave in the order the
// pixels came in. Throughput is one pixel per cycle. The divider resolves
// one quotient bit per stage: CHANNEL_BITS stages for the saturation
// quotient and six for the hue quotient, side by side.
// Brightness is the largest channel, saturation is the full-scale code times
// (max - min) divided by max, and hue is in whole degrees from 0 to 359.
// Reset clears the valid bits of every stage, so no result is shown until a
// pixel has been accepted after reset. The receiver cannot hold results off,
// so there is no back-pressure anywhere in the pipeline.
module rgb_to_hsv_converter_top #(
  parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [CHANNEL_BITS-1:0]         red_in_i,
  input  logic [CHANNEL_BITS-1:0]         green_in_i,
  input  logic [CHANNEL_BITS-1:0]         blue_in_i,
  output logic                            done_o,
  output logic [rgbhsv_pkg::HUE_BITS-1:0] hue_deg_o,
  output logic [CHANNEL_BITS-1:0]         saturation_o,
  output logic [CHANNEL_BITS-1:0]         brightness_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned W = CHANNEL_BITS;

  // Prepare stages to divider.
  rgbhsv_ctrl_t             prep_ctrl;
  logic [W-1:0]             prep_max, prep_delta;
  logic [W+HUE_QBITS-1:0]   prep_hue_num;
  logic [2*W-1:0]           prep_sat_num;

  // Divider to output stage.
  rgbhsv_ctrl_t             div_ctrl;
  logic [W-1:0]             div_max, div_sat_quo;
  logic [HUE_QBITS-1:0]     div_hue_quo;

  // Every cycle is open for a new pixel.
  assign busy_o = 1'b0;

  rgbhsv_prep #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .red_i     (red_in_i),
    .green_i   (green_in_i),
    .blue_i    (blue_in_i),
    .ctrl_o    (prep_ctrl),
    .max_o     (prep_max),
    .delta_o   (prep_delta),
    .hue_num_o (prep_hue_num),
    .sat_num_o (prep_sat_num)
  );

  rgbhsv_div #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (prep_ctrl),
    .max_i     (prep_max),
    .delta_i   (prep_delta),
    .hue_num_i (prep_hue_num),
    .sat_num_i (prep_sat_num),
    .ctrl_o    (div_ctrl),
    .max_o     (div_max),
    .hue_quo_o (div_hue_quo),
    .sat_quo_o (div_sat_quo)
  );

  rgbhsv_final #(
    .CHANNEL_BITS(CHANNEL_BITS)
  ) u_final (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (div_ctrl),
    .max_i        (div_max),
    .hue_quo_i    (div_hue_quo),
    .sat_quo_i    (div_sat_quo),
    .done_o       (done_o),
    .hue_deg_o    (hue_deg_o),
    .saturation_o (saturation_o),
    .brightness_o (brightness_o)
  );

endmodule

// ===== hdl/rgbhsv_checker.sv =====
`include "assert_macros.svh"

module rgbhsv_checker #(
  parameter int unsigned CHANNEL_BITS = rgbhsv_pkg::CHANNEL_BITS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic [CHANNEL_BITS-1:0]         red_in_i,
  input logic [CHANNEL_BITS-1:0]         green_in_i,
  input logic [CHANNEL_BITS-1:0]         blue_in_i,
  input logic                            done_o,
  input logic [rgbhsv_pkg::HUE_BITS-1:0] hue_deg_o,
  input logic [CHANNEL_BITS-1:0]         saturation_o,
  input logic [CHANNEL_BITS-1:0]         brightness_o
);
  import rgbhsv_pkg::*;

  localparam int unsigned LATENCY =
    ((CHANNEL_BITS > HUE_QBITS) ? CHANNEL_BITS : HUE_QBITS) + EXTRA_STAGES;

  logic accepted;
  assign accepted = start_i && !busy_o;

  // Every accepted pixel produces its result after the fixed latency.
  `ASSERT_IMPLY(a_result_follows, clk_i, rst_ni, accepted, ##LATENCY done_o)

  // A result may only appear for a pixel accepted outside reset.
  `ASSERT_IMPLY(a_no_spurious, clk_i, rst_ni, done_o, $past(accepted && rst_ni, LATENCY))

  // Hue stays on the circle.
  `ASSERT_IMPLY(a_hue_range, clk_i, rst_ni, done_o, (hue_deg_o < HUE_BITS'(HUE_FULL_TURN)))

  // Zero saturation means a grey pixel, whose hue is zero.
  `ASSERT_IMPLY(a_grey_hue, clk_i, rst_ni, done_o && (saturation_o == '0), (hue_deg_o == '0))

  // Nonzero saturation needs a nonzero brightness.
  `ASSERT_IMPLY(a_sat_bright, clk_i, rst_ni, done_o && (saturation_o != '0), (brightness_o != '0))

endmodule

bind rgb_to_hsv_converter_top rgbhsv_checker #(
  .CHANNEL_BITS(CHANNEL_BITS)
) u_rgbhsv_checker (.*);
